// ===== rtl/core/rgdrh_pkg.sv =====
package rgdrh_pkg;

  localparam int VAL_W     = 16;
  localparam int RATE_W    = 17;
  localparam int COORD_W   = 7;
  localparam int PIN_W     = 6;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;
  localparam int TOT_W     = 28;
  localparam int SUM_W     = 30;
  localparam int NSUM_W    = 18;
  localparam int NCNT_W    = 3;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;
  localparam logic [TOT_W-1:0]  TOT_MAX  = '1;
  // ceil(2^20 / 3); exact floor division for sums below 2^19
  localparam logic [18:0]       DIV3_MUL = 19'd349526;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIFFUSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REGROW  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_HARVEST = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXRES = 3'd5;

  localparam logic [COORD_W-1:0] RST_GRID_W = 7'd64;
  localparam logic [COORD_W-1:0] RST_GRID_H = 7'd64;
  localparam logic [VAL_W-1:0]   RST_MAXRES = 16'hFFFF;

  typedef struct packed {
    logic              vld;
    logic [NSUM_W-1:0] sum;
    logic [NCNT_W-1:0] cnt;
    logic [VAL_W-1:0]  val;
  } mix_req_t;

  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } mix_rsp_t;

endpackage

// ===== rtl/core/rgdrh_ram.sv =====
module rgdrh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_q_r;

endmodule

// ===== rtl/core/rgdrh_mix.sv =====
module rgdrh_mix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rgdrh_pkg::mix_req_t              req,
  input  logic [rgdrh_pkg::RATE_W-1:0]     rate,
  output rgdrh_pkg::mix_rsp_t              rsp
);
  import rgdrh_pkg::*;

  logic                    v1_r, v2_r, v3_r;
  logic [VAL_W-1:0]        mean_r, val1_r, val2_r, out_r;
  logic [VAL_W-1:0]        mean_nxt, out_nxt;
  logic [36:0]             q3;
  logic signed [16:0]      diff_s;
  logic signed [17:0]      rate_s;
  logic signed [34:0]      prod_r, prod_nxt;
  logic signed [35:0]      acc;

  assign q3 = 37'(req.sum) * 37'(DIV3_MUL);

  always_comb begin
    case (req.cnt)
      3'd0:    mean_nxt = req.val;
      3'd1:    mean_nxt = req.sum[VAL_W-1:0];
      3'd2:    mean_nxt = req.sum[VAL_W:1];
      3'd3:    mean_nxt = q3[35:20];
      default: mean_nxt = req.sum[VAL_W+1:2];
    endcase
  end

  assign diff_s   = $signed({1'b0, mean_r}) - $signed({1'b0, val1_r});
  assign rate_s   = $signed({1'b0, rate});
  assign prod_nxt = 35'(diff_s) * 35'(rate_s);

  assign acc = $signed({4'b0, val2_r, 16'b0}) + 36'(prod_r);

  always_comb begin
    if (acc < 0) begin
      out_nxt = '0;
    end else if (acc[35:32] != 4'b0) begin
      out_nxt = '1;
    end else begin
      out_nxt = acc[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    mean_r <= mean_nxt;
    val1_r <= req.val;
    prod_r <= prod_nxt;
    val2_r <= val1_r;
    out_r  <= out_nxt;
  end

  assign rsp.vld = v3_r;
  assign rsp.val = out_r;

endmodule

// ===== rtl/core/resource_grid_diffuse_regrow_harvest.sv =====
// Resource grid with load, diffuse, regrow and harvest commands; one result
// per command carrying the harvested amount and the grid total. After reset
// the grid memory is cleared one cell per cycle before the first command is
// taken. Load and harvest do one read-modify-write of the grid memory; a
// load or harvest outside the grid, a harvest of zero and a diffuse with zero
// rate leave the grid memory untouched. Regrow goes one cell per cycle
// through the read port of the grid memory. Diffuse reads each cell and its
// neighbors on the single grid read port and passes them through the
// three-stage mixing pipeline, finishing one cell before it starts the next;
// then the scratch buffer is copied back one cell per cycle. The first
// command after grid_width or grid_height is written first runs a sweep over
// the grid to recompute the total. The next input transfer can happen in the
// cycle the result goes valid; a result still waiting on out_ready holds the
// next result, and with it the input, until it is taken.
module resource_grid_diffuse_regrow_harvest #(
  parameter int MAX_WIDTH  = rgdrh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgdrh_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rgdrh_pkg::CMD_W-1:0]        in_command,
  input  logic [rgdrh_pkg::PIN_W-1:0]        in_cell_x,
  input  logic [rgdrh_pkg::PIN_W-1:0]        in_cell_y,
  input  logic [rgdrh_pkg::VAL_W-1:0]        in_amount,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rgdrh_pkg::VAL_W-1:0]        out_harvested,
  output logic [rgdrh_pkg::TOT_W-1:0]        out_total,
  input  logic                               cfg_we,
  input  logic [rgdrh_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [rgdrh_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import rgdrh_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_PT_WR = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_SWEEP = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  localparam logic [1:0] M_SUM  = 2'd0;
  localparam logic [1:0] M_COPY = 2'd1;
  localparam logic [1:0] M_GROW = 2'd2;

  function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
    addr_of = AW'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  logic [3:0]           state_r;
  logic [1:0]           mode_r;
  logic                 dirty_r;
  logic [COORD_W-1:0]   cfg_gw_r, cfg_gh_r;
  logic                 cfg_wrap_r;
  logic [RATE_W-1:0]    cfg_drate_r, cfg_grate_r;
  logic [VAL_W-1:0]     cfg_max_r;

  logic [CMD_W-1:0]     cmd_r;
  logic [PIN_W-1:0]     px_r, py_r;
  logic [VAL_W-1:0]     amt_r, harv_r, add_r, val_r;
  logic [COORD_W-1:0]   cx_r, cy_r;
  logic [2:0]           ph_r;
  logic [AW-1:0]        clr_addr_r, sw_addr_r;
  logic                 sw_vld_r, take_r;
  logic [NSUM_W-1:0]    nsum_r;
  logic [NCNT_W-1:0]    ncnt_r;
  logic [SUM_W-1:0]     total_r;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_harv_r;
  logic [TOT_W-1:0]     out_tot_r;

  logic [COORD_W-1:0]   w_eff, h_eff, nb_x, nb_y;
  logic                 nb_vld, last_cell, in_grid;
  logic [RATE_W-1:0]    drate_sat, grate_sat;
  logic [32:0]          grow_prod;
  logic [NSUM_W-1:0]    sum_cur;
  logic [NCNT_W-1:0]    cnt_cur;
  logic [VAL_W-1:0]     res_rd, nxt_rd, sw_src, sw_val, taken;
  logic [VAL_W:0]       grow_sum;
  logic [AW-1:0]        pt_addr, cur_addr, res_rd_addr, res_wr_addr;
  logic                 res_we;
  logic [VAL_W-1:0]     res_wr_data;
  logic                 nxt_we;
  mix_req_t             mix_req;
  mix_rsp_t             mix_rsp;

  always_comb begin
    if (cfg_gw_r == '0) begin
      w_eff = 7'd1;
    end else if (int'(cfg_gw_r) > MAX_WIDTH) begin
      w_eff = COORD_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_gw_r;
    end
    if (cfg_gh_r == '0) begin
      h_eff = 7'd1;
    end else if (int'(cfg_gh_r) > MAX_HEIGHT) begin
      h_eff = COORD_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_gh_r;
    end
  end

  assign drate_sat = (cfg_drate_r > RATE_ONE) ? RATE_ONE : cfg_drate_r;
  assign grate_sat = (cfg_grate_r > RATE_ONE) ? RATE_ONE : cfg_grate_r;
  assign grow_prod = 33'(grate_sat) * 33'(cfg_max_r);

  assign last_cell = (cx_r == w_eff - 7'd1) && (cy_r == h_eff - 7'd1);
  assign in_grid   = ({1'b0, px_r} < w_eff) && ({1'b0, py_r} < h_eff);
  assign pt_addr   = addr_of({1'b0, px_r}, {1'b0, py_r});
  assign cur_addr  = addr_of(cx_r, cy_r);

  // neighbor order: self, east, west, south, north
  always_comb begin
    nb_x   = cx_r;
    nb_y   = cy_r;
    nb_vld = 1'b0;
    case (ph_r)
      3'd0: nb_vld = 1'b1;
      3'd1: begin
        nb_vld = cfg_wrap_r || (cx_r + 7'd1 < w_eff);
        nb_x   = (cx_r + 7'd1 == w_eff) ? 7'd0 : cx_r + 7'd1;
      end
      3'd2: begin
        nb_vld = cfg_wrap_r || (cx_r != '0);
        nb_x   = (cx_r == '0) ? w_eff - 7'd1 : cx_r - 7'd1;
      end
      3'd3: begin
        nb_vld = cfg_wrap_r || (cy_r + 7'd1 < h_eff);
        nb_y   = (cy_r + 7'd1 == h_eff) ? 7'd0 : cy_r + 7'd1;
      end
      3'd4: begin
        nb_vld = cfg_wrap_r || (cy_r != '0);
        nb_y   = (cy_r == '0) ? h_eff - 7'd1 : cy_r - 7'd1;
      end
      default: nb_vld = 1'b0;
    endcase
  end

  assign sum_cur = nsum_r + (take_r ? NSUM_W'(res_rd) : '0);
  assign cnt_cur = ncnt_r + NCNT_W'(take_r);

  assign mix_req.vld = (state_r == S_DIFF) && (ph_r == 3'd5);
  assign mix_req.sum = sum_cur;
  assign mix_req.cnt = cnt_cur;
  assign mix_req.val = val_r;

  assign sw_src   = (mode_r == M_COPY) ? nxt_rd : res_rd;
  assign grow_sum = {1'b0, sw_src} + {1'b0, add_r};
  assign sw_val   = (mode_r == M_GROW) ?
                    ((grow_sum > {1'b0, cfg_max_r}) ? cfg_max_r : grow_sum[VAL_W-1:0]) :
                    sw_src;
  assign taken    = (amt_r < res_rd) ? amt_r : res_rd;

  always_comb begin
    case (state_r)
      S_DIFF:  res_rd_addr = addr_of(nb_x, nb_y);
      S_SWEEP: res_rd_addr = cur_addr;
      default: res_rd_addr = pt_addr;
    endcase
  end

  always_comb begin
    res_we      = 1'b0;
    res_wr_addr = sw_addr_r;
    res_wr_data = sw_val;
    if (state_r == S_CLEAR) begin
      res_we      = 1'b1;
      res_wr_addr = clr_addr_r;
      res_wr_data = '0;
    end else if (state_r == S_PT_WR) begin
      res_we      = 1'b1;
      res_wr_addr = pt_addr;
      res_wr_data = (cmd_r == CMD_LOAD) ? amt_r : res_rd - taken;
    end else if (sw_vld_r && (mode_r != M_SUM)) begin
      res_we = 1'b1;
    end
  end

  assign nxt_we = (state_r == S_DWAIT) && mix_rsp.vld;

  rgdrh_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_res_ram (
    .clk     (clk),
    .we      (res_we),
    .wr_addr (res_wr_addr),
    .wr_data (res_wr_data),
    .rd_addr (res_rd_addr),
    .rd_data (res_rd)
  );

  rgdrh_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_nxt_ram (
    .clk     (clk),
    .we      (nxt_we),
    .wr_addr (cur_addr),
    .wr_data (mix_rsp.val),
    .rd_addr (cur_addr),
    .rd_data (nxt_rd)
  );

  rgdrh_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mix_req),
    .rate  (drate_sat),
    .rsp   (mix_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      mode_r      <= M_SUM;
      dirty_r     <= 1'b0;
      clr_addr_r  <= '0;
      sw_vld_r    <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      cfg_gw_r    <= RST_GRID_W;
      cfg_gh_r    <= RST_GRID_H;
      cfg_wrap_r  <= 1'b1;
      cfg_drate_r <= '0;
      cfg_grate_r <= '0;
      cfg_max_r   <= RST_MAXRES;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_GRID_W: begin
            cfg_gw_r <= cfg_wdata[COORD_W-1:0];
            dirty_r  <= 1'b1;
          end
          CFG_GRID_H: begin
            cfg_gh_r <= cfg_wdata[COORD_W-1:0];
            dirty_r  <= 1'b1;
          end
          CFG_WRAP:   cfg_wrap_r  <= cfg_wdata[0];
          CFG_DRATE:  cfg_drate_r <= cfg_wdata;
          CFG_GRATE:  cfg_grate_r <= cfg_wdata;
          CFG_MAXRES: cfg_max_r   <= cfg_wdata[VAL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end

      sw_vld_r <= 1'b0;
      if (sw_vld_r) begin
        total_r <= total_r + SUM_W'(sw_val);
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= in_command;
            px_r   <= in_cell_x;
            py_r   <= in_cell_y;
            amt_r  <= in_amount;
            harv_r <= '0;
            if (dirty_r) begin
              dirty_r <= 1'b0;
              cx_r    <= '0;
              cy_r    <= '0;
              mode_r  <= M_SUM;
              total_r <= '0;
              state_r <= S_SWEEP;
            end else begin
              state_r <= S_DISP;
            end
          end
        end
        S_DISP: begin
          cx_r <= '0;
          cy_r <= '0;
          ph_r <= '0;
          unique case (cmd_r)
            CMD_LOAD:    state_r <= in_grid ? S_PT_WR : S_RESP;
            CMD_HARVEST: state_r <= (in_grid && amt_r != '0) ? S_PT_WR : S_RESP;
            CMD_DIFFUSE: state_r <= (drate_sat == '0) ? S_RESP : S_DIFF;
            CMD_REGROW: begin
              add_r   <= grow_prod[31:16];
              mode_r  <= M_GROW;
              total_r <= '0;
              state_r <= S_SWEEP;
            end
            default: state_r <= S_RESP;
          endcase
        end
        S_PT_WR: begin
          if (cmd_r == CMD_LOAD) begin
            total_r <= total_r - SUM_W'(res_rd) + SUM_W'(amt_r);
          end else begin
            total_r <= total_r - SUM_W'(taken);
            harv_r  <= taken;
          end
          state_r <= S_RESP;
        end
        S_DIFF: begin
          if (ph_r == 3'd0) begin
            nsum_r <= '0;
            ncnt_r <= '0;
            take_r <= 1'b0;
          end else begin
            nsum_r <= sum_cur;
            ncnt_r <= cnt_cur;
            take_r <= nb_vld;
          end
          if (ph_r == 3'd1) begin
            val_r <= res_rd;
          end
          if (ph_r == 3'd5) begin
            state_r <= S_DWAIT;
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        S_DWAIT: begin
          if (mix_rsp.vld) begin
            ph_r <= '0;
            if (last_cell) begin
              cx_r    <= '0;
              cy_r    <= '0;
              mode_r  <= M_COPY;
              total_r <= '0;
              state_r <= S_SWEEP;
            end else begin
              if (cx_r == w_eff - 7'd1) begin
                cx_r <= '0;
                cy_r <= cy_r + 7'd1;
              end else begin
                cx_r <= cx_r + 7'd1;
              end
              state_r <= S_DIFF;
            end
          end
        end
        S_SWEEP: begin
          sw_vld_r  <= 1'b1;
          sw_addr_r <= cur_addr;
          if (last_cell) begin
            state_r <= S_DRAIN;
          end else if (cx_r == w_eff - 7'd1) begin
            cx_r <= '0;
            cy_r <= cy_r + 7'd1;
          end else begin
            cx_r <= cx_r + 7'd1;
          end
        end
        S_DRAIN: begin
          state_r <= (mode_r == M_SUM) ? S_DISP : S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_harv_r  <= harv_r;
            out_tot_r   <= (total_r > SUM_W'(TOT_MAX)) ? TOT_MAX : total_r[TOT_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_harvested = out_harv_r;
  assign out_total     = out_tot_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clear");

  a_mix_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mix_rsp.vld |-> (state_r == S_DWAIT))
    else $error("mix result outside wait state");

  a_mix_latency: assert property (@(posedge clk) disable iff (!rst_n)
    mix_req.vld |-> ##3 mix_rsp.vld)
    else $error("mix pipeline latency broken");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !res_we && !nxt_we)
    else $error("grid write while idle");

  a_transfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("transfer did not start a command");
`endif

endmodule
